// File: src/qubt_pkg.sv
// Shared types and constants of the queued UART bit transmitter.
package qubt_pkg;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_DATA = 2'd1,
        PH_STOP = 2'd2,
        PH_GAP  = 2'd3
    } t_phase;

    localparam logic       OP_TICK         = 1'b0;
    localparam logic       OP_BYTE         = 1'b1;
    localparam logic [7:0] TICK_MAX        = 8'd255;
    localparam logic [7:0] BIT_TICKS_RESET = 8'd2;
    localparam logic [3:0] DATA_BITS       = 4'd8;

    typedef struct packed {
        logic       opcode;
        logic [7:0] data_byte;
        logic       last_byte;
    } t_item;

    typedef struct packed {
        logic       tx_line;
        logic       busy_res;
        logic       dropped;
        logic [2:0] pending;
    } t_result;

endpackage

// File: src/qubt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module qubt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/qubt_ctrl.sv
// Ring, fill and sender state with write access and forwarded reads of the message memories.
module qubt_ctrl #(
    parameter int MSG_SLOTS = 8,
    parameter int MSG_BYTES = 16,
    localparam int SLOT_W = $clog2(MSG_SLOTS),
    localparam int OFS_W  = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1,
    localparam int POS_W  = $clog2(MSG_BYTES + 1),
    localparam int ADDR_W = SLOT_W + OFS_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  qubt_pkg::t_item       i_item,
    input  logic [7:0]            i_bit_ticks,
    output logic                  o_st_we,
    output logic [ADDR_W-1:0]     o_st_waddr,
    output logic [7:0]            o_st_wdata,
    output logic [ADDR_W-1:0]     o_st_raddr,
    input  logic [7:0]            i_st_rdata,
    output logic                  o_len_we,
    output logic [SLOT_W-1:0]     o_len_waddr,
    output logic [POS_W-1:0]      o_len_wdata,
    output logic [SLOT_W-1:0]     o_len_raddr,
    input  logic [POS_W-1:0]      i_len_rdata,
    output qubt_pkg::t_result     o_result
);
    import qubt_pkg::*;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MSG_SLOTS - 1);
    localparam logic [POS_W-1:0]  BYTES_MAX = POS_W'(MSG_BYTES);
    localparam int                DIFF_W    = (SLOT_W + 1 > 3) ? SLOT_W + 1 : 3;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        return (s == LAST_SLOT) ? '0 : s + 1'b1;
    endfunction

    function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
        return (s == '0) ? LAST_SLOT : s - 1'b1;
    endfunction

    t_phase              r_phase, n_phase;
    logic [3:0]          r_bit_index, n_bit_index;
    logic [7:0]          r_shift_byte, n_shift_byte;
    logic [7:0]          r_tick_count, n_tick_count;
    logic                r_line_level, n_line_level;
    logic [SLOT_W-1:0]   r_ring_head, n_ring_head;
    logic [SLOT_W-1:0]   r_ring_tail, n_ring_tail;
    logic [POS_W-1:0]    r_fill_position, n_fill_position;
    logic [POS_W-1:0]    r_send_position, n_send_position;
    logic                r_sfwd_hit, n_sfwd_hit;
    logic [7:0]          r_sfwd_data;
    logic                r_lfwd_hit, n_lfwd_hit;
    logic [POS_W-1:0]    r_lfwd_data;

    logic [7:0]          bt;
    logic                is_byte;
    logic                room;
    logic                full;
    logic [SLOT_W-1:0]   head_next;
    logic [SLOT_W-1:0]   head_after;
    logic [POS_W-1:0]    fill_after;
    logic                commit;
    logic                dropped;
    logic [7:0]          tick_in;
    logic [ADDR_W-1:0]   cur_raddr;
    logic [7:0]          load_byte;
    logic [POS_W-1:0]    len_cur;
    logic [DIFF_W-1:0]   pend;

    assign bt         = (i_bit_ticks == 8'd0) ? 8'd1 : i_bit_ticks;
    assign is_byte    = (i_item.opcode == OP_BYTE);
    assign room       = (r_fill_position < BYTES_MAX);
    assign head_next  = slot_inc(r_ring_head);
    assign full       = (head_next == r_ring_tail);
    assign fill_after = room ? r_fill_position + 1'b1 : r_fill_position;
    assign commit     = i_adv && is_byte && i_item.last_byte && !full;
    assign dropped    = is_byte && (!room || (i_item.last_byte && full));
    assign head_after = commit ? head_next : r_ring_head;
    assign tick_in    = (!is_byte && r_tick_count != TICK_MAX) ? r_tick_count + 8'd1
                                                               : r_tick_count;

    assign o_st_we     = i_adv && is_byte && room;
    assign o_st_waddr  = {r_ring_head, r_fill_position[OFS_W-1:0]};
    assign o_st_wdata  = i_item.data_byte;
    assign o_len_we    = commit;
    assign o_len_waddr = r_ring_head;
    assign o_len_wdata = fill_after;

    assign cur_raddr = (r_phase == PH_IDLE) ? {r_ring_tail, {OFS_W{1'b0}}}
                     : {slot_dec(r_ring_tail), r_send_position[OFS_W-1:0]};
    assign load_byte = (o_st_we && o_st_waddr == cur_raddr) ? i_item.data_byte
                     : (r_sfwd_hit ? r_sfwd_data : i_st_rdata);
    assign len_cur   = r_lfwd_hit ? r_lfwd_data : i_len_rdata;

    always_comb begin
        t_phase            ph;
        logic [7:0]        tk;
        logic              lv;
        logic [3:0]        bi;
        logic [7:0]        sb;
        logic [SLOT_W-1:0] tl;
        logic [POS_W-1:0]  sp;
        ph = r_phase;
        tk = tick_in;
        lv = r_line_level;
        bi = r_bit_index;
        sb = r_shift_byte;
        tl = r_ring_tail;
        sp = r_send_position;
        case (ph)
            PH_IDLE: begin
                if (tl != head_after) begin
                    tl = slot_inc(tl);
                    sp = '0;
                    ph = PH_GAP;
                    if (tk >= bt) begin
                        sb = load_byte;
                        sp = sp + 1'b1;
                        lv = 1'b0;
                        bi = '0;
                        tk = '0;
                        ph = PH_DATA;
                    end
                end
            end
            PH_GAP: begin
                if (tk >= bt) begin
                    sb = load_byte;
                    sp = sp + 1'b1;
                    lv = 1'b0;
                    bi = '0;
                    tk = '0;
                    ph = PH_DATA;
                end
            end
            PH_DATA: begin
                if (tk >= bt) begin
                    lv = sb[bi[2:0]];
                    tk = '0;
                    bi = bi + 4'd1;
                    if (bi >= DATA_BITS) begin
                        ph = PH_STOP;
                    end
                end
            end
            PH_STOP: begin
                if (tk >= bt) begin
                    lv = 1'b1;
                    bi = '0;
                    tk = '0;
                    ph = PH_GAP;
                    if (sp >= len_cur) begin
                        ph = PH_IDLE;
                        if (tl != head_after) begin
                            tl = slot_inc(tl);
                            sp = '0;
                            ph = PH_GAP;
                        end
                    end
                end
            end
            default: begin
                ph = PH_IDLE;
            end
        endcase

        pend = DIFF_W'(head_after) - DIFF_W'(tl);
        if (head_after < tl) begin
            pend = pend + DIFF_W'(MSG_SLOTS);
        end

        o_result.tx_line  = lv;
        o_result.busy_res = (ph != PH_IDLE);
        o_result.dropped  = dropped;
        o_result.pending  = pend[2:0];

        n_phase         = r_phase;
        n_tick_count    = r_tick_count;
        n_line_level    = r_line_level;
        n_bit_index     = r_bit_index;
        n_shift_byte    = r_shift_byte;
        n_ring_tail     = r_ring_tail;
        n_ring_head     = r_ring_head;
        n_send_position = r_send_position;
        n_fill_position = r_fill_position;
        if (i_adv) begin
            n_phase         = ph;
            n_tick_count    = tk;
            n_line_level    = lv;
            n_bit_index     = bi;
            n_shift_byte    = sb;
            n_ring_tail     = tl;
            n_ring_head     = head_after;
            n_send_position = sp;
            if (is_byte) begin
                n_fill_position = i_item.last_byte ? '0 : fill_after;
            end
        end
    end

    assign o_st_raddr  = (n_phase == PH_IDLE) ? {n_ring_tail, {OFS_W{1'b0}}}
                       : {slot_dec(n_ring_tail), n_send_position[OFS_W-1:0]};
    assign o_len_raddr = slot_dec(n_ring_tail);
    assign n_sfwd_hit  = o_st_we && (o_st_waddr == o_st_raddr);
    assign n_lfwd_hit  = o_len_we && (o_len_waddr == o_len_raddr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_bit_index     <= '0;
            r_shift_byte    <= '0;
            r_tick_count    <= BIT_TICKS_RESET;
            r_line_level    <= 1'b1;
            r_ring_head     <= '0;
            r_ring_tail     <= '0;
            r_fill_position <= '0;
            r_send_position <= '0;
            r_sfwd_hit      <= 1'b0;
            r_lfwd_hit      <= 1'b0;
        end else begin
            r_phase         <= n_phase;
            r_bit_index     <= n_bit_index;
            r_shift_byte    <= n_shift_byte;
            r_tick_count    <= n_tick_count;
            r_line_level    <= n_line_level;
            r_ring_head     <= n_ring_head;
            r_ring_tail     <= n_ring_tail;
            r_fill_position <= n_fill_position;
            r_send_position <= n_send_position;
            r_sfwd_hit      <= n_sfwd_hit;
            r_lfwd_hit      <= n_lfwd_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sfwd_data <= o_st_wdata;
        r_lfwd_data <= o_len_wdata;
    end

endmodule

// File: src/queued_uart_bit_transmitter.sv
// Queued 8N1 UART bit transmitter: top level with handshakes, memories and result register.
//
// Input channel (i_valid / o_stall): each transaction is either a timer tick
// (opcode 0) or one message byte (opcode 1, last_byte ends the message).
// Output channel (o_valid / i_stall): one result per input transaction, in
// order: line level, busy flag, drop flag and number of waiting messages.
// Configuration channel (i_cfg_valid / o_cfg_ready): writes bit_ticks; ready
// is always high. Write it only while no transaction is in flight.
// Throughput is one transaction per clock while i_stall does not hold a result. A taken
// transaction is loaded into the processing stage, which uses the registered reads of the
// message store and length memory, and its result is then loaded into the result register
// when that register is free to advance.
// Reset clears the ring, the sender and both handshake stages at once; the
// memories need no clearing pass. While i_stall holds a result, one more
// transaction is taken into the processing stage, after which o_stall rises
// until the result register drains.
module queued_uart_bit_transmitter #(
    parameter int MSG_SLOTS = 8,
    parameter int MSG_BYTES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_opcode,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_tx_line,
    output logic       o_busy_res,
    output logic       o_dropped,
    output logic [2:0] o_pending,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);
    import qubt_pkg::*;

    localparam int SLOT_W      = $clog2(MSG_SLOTS);
    localparam int OFS_W       = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;
    localparam int POS_W       = $clog2(MSG_BYTES + 1);
    localparam int ADDR_W      = SLOT_W + OFS_W;
    localparam int STORE_DEPTH = MSG_SLOTS << OFS_W;

    logic              r_s1_valid, n_s1_valid;
    t_item             r_s1_item;
    logic              r_out_valid, n_out_valid;
    t_result           r_out;
    logic [7:0]        r_bit_ticks;

    logic              w_adv;
    logic              w_in_acc;
    t_result           w_result;
    logic              w_st_we;
    logic [ADDR_W-1:0] w_st_waddr;
    logic [7:0]        w_st_wdata;
    logic [ADDR_W-1:0] w_st_raddr;
    logic [7:0]        w_st_rdata;
    logic              w_len_we;
    logic [SLOT_W-1:0] w_len_waddr;
    logic [POS_W-1:0]  w_len_wdata;
    logic [SLOT_W-1:0] w_len_raddr;
    logic [POS_W-1:0]  w_len_rdata;

    assign w_adv       = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall     = r_s1_valid && r_out_valid && i_stall;
    assign w_in_acc    = i_valid && !o_stall;
    assign n_s1_valid  = w_in_acc || (r_s1_valid && !w_adv);
    assign n_out_valid = w_adv || (r_out_valid && i_stall);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_bit_ticks <= BIT_TICKS_RESET;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_bit_ticks <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_item.opcode    <= i_opcode;
            r_s1_item.data_byte <= i_data_byte;
            r_s1_item.last_byte <= i_last_byte;
        end
        if (w_adv) begin
            r_out <= w_result;
        end
    end

    qubt_ram #(
        .WIDTH(8),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_st_we),
        .i_waddr(w_st_waddr),
        .i_wdata(w_st_wdata),
        .i_raddr(w_st_raddr),
        .o_rdata(w_st_rdata)
    );

    qubt_ram #(
        .WIDTH(POS_W),
        .DEPTH(MSG_SLOTS)
    ) u_length (
        .i_clk  (i_clk),
        .i_we   (w_len_we),
        .i_waddr(w_len_waddr),
        .i_wdata(w_len_wdata),
        .i_raddr(w_len_raddr),
        .o_rdata(w_len_rdata)
    );

    qubt_ctrl #(
        .MSG_SLOTS(MSG_SLOTS),
        .MSG_BYTES(MSG_BYTES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (w_adv),
        .i_item     (r_s1_item),
        .i_bit_ticks(r_bit_ticks),
        .o_st_we    (w_st_we),
        .o_st_waddr (w_st_waddr),
        .o_st_wdata (w_st_wdata),
        .o_st_raddr (w_st_raddr),
        .i_st_rdata (w_st_rdata),
        .o_len_we   (w_len_we),
        .o_len_waddr(w_len_waddr),
        .o_len_wdata(w_len_wdata),
        .o_len_raddr(w_len_raddr),
        .i_len_rdata(w_len_rdata),
        .o_result   (w_result)
    );

    assign o_valid    = r_out_valid;
    assign o_tx_line  = r_out.tx_line;
    assign o_busy_res = r_out.busy_res;
    assign o_dropped  = r_out.dropped;
    assign o_pending  = r_out.pending;

    a_adv_makes_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> o_valid)
        else $error("processed transaction produced no result");

    a_no_stage_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && r_s1_valid) |-> w_adv)
        else $error("processing stage overwritten while held");

    a_idle_ring_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_busy_res) |-> (o_pending == 3'd0))
        else $error("sender idle while messages wait");

    a_idle_line_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_busy_res) |-> o_tx_line)
        else $error("line low while sender idle");

endmodule

// File: bench/tb_queued_uart_bit_transmitter.sv
// Testbench for the queued UART bit transmitter: directed rows, then random traffic per bit time.
`timescale 1ns / 100ps

module tb_queued_uart_bit_transmitter;

    import qubt_pkg::*;

    localparam int SLOTS       = 8;
    localparam int BYTES       = 16;
    localparam int TOTAL_ITEMS = 1150;
    localparam int CYCLE_LIMIT = 400000;
    localparam int NUM_ROWS    = 22;

    typedef struct packed {
        t_item   it;
        logic    typed;
        t_result res;
    } t_row;

    // op, data, last | typed | tx_line, busy, dropped, pending
    localparam t_row DIRECTED_ROWS [NUM_ROWS] = '{
        {OP_TICK, 8'h3C, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 3'd0},
        {OP_BYTE, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 3'd0},
        {OP_BYTE, 8'hFF, 1'b1, 1'b0, 6'd0},
        {OP_BYTE, 8'h01, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 3'd1},
        {OP_BYTE, 8'h02, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 3'd2},
        {OP_BYTE, 8'h04, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 3'd3},
        {OP_BYTE, 8'h08, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 3'd4},
        {OP_BYTE, 8'h10, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 3'd5},
        {OP_BYTE, 8'h20, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 3'd6},
        {OP_BYTE, 8'h40, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 3'd7},
        {OP_BYTE, 8'h80, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 3'd7},
        {OP_BYTE, 8'hA5, 1'b0, 1'b0, 6'd0},
        {OP_BYTE, 8'h5A, 1'b0, 1'b0, 6'd0},
        {OP_TICK, 8'hFF, 1'b1, 1'b0, 6'd0},
        {OP_TICK, 8'h00, 1'b0, 1'b0, 6'd0},
        {OP_TICK, 8'hAA, 1'b1, 1'b0, 6'd0},
        {OP_TICK, 8'h55, 1'b0, 1'b0, 6'd0},
        {OP_TICK, 8'h0F, 1'b1, 1'b0, 6'd0},
        {OP_TICK, 8'hF0, 1'b0, 1'b0, 6'd0},
        {OP_TICK, 8'h81, 1'b1, 1'b0, 6'd0},
        {OP_TICK, 8'h7E, 1'b0, 1'b0, 6'd0},
        {OP_TICK, 8'hC3, 1'b1, 1'b0, 6'd0}
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic       i_opcode = 1'b0;
    logic [7:0] i_data_byte = 8'd0;
    logic       i_last_byte = 1'b0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic       o_tx_line;
    logic       o_busy_res;
    logic       o_dropped;
    logic [2:0] o_pending;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_data = 8'd0;

    queued_uart_bit_transmitter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_opcode    (i_opcode),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_tx_line   (o_tx_line),
        .o_busy_res  (o_busy_res),
        .o_dropped   (o_dropped),
        .o_pending   (o_pending),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    t_phase     line_phase;
    logic [3:0] bit_pos;
    logic [7:0] shift_reg;
    logic [7:0] tick_cnt;
    logic       line_lvl;
    logic [7:0] msg_mem [SLOTS*BYTES];
    logic [4:0] msg_len [SLOTS];
    logic [2:0] head;
    logic [2:0] tail;
    logic [4:0] fill_pos;
    logic [4:0] send_pos;
    logic [7:0] bit_ticks_cfg;

    t_result expected_lines [$];
    int      items_sent = 0;
    int      errors = 0;
    int      cycles = 0;
    int      tx_calm = 0;
    int      rx_calm = 0;
    int      stall_left = 0;
    bit      quiet = 1'b0;

    function automatic bit sender_advance();
        logic [7:0] bt;
        logic [2:0] wire_slot;
        bt = (bit_ticks_cfg == 8'd0) ? 8'd1 : bit_ticks_cfg;
        wire_slot = tail - 3'd1;
        case (line_phase)
            PH_IDLE: begin
                if (tail != head) begin
                    tail = tail + 3'd1;
                    send_pos = 5'd0;
                    line_phase = PH_GAP;
                    return 1'b1;
                end
                return 1'b0;
            end
            PH_GAP: begin
                if (send_pos >= msg_len[wire_slot]) begin
                    line_phase = PH_IDLE;
                    return 1'b1;
                end
                if (tick_cnt >= bt) begin
                    shift_reg = msg_mem[{wire_slot, send_pos[3:0]}];
                    send_pos = send_pos + 5'd1;
                    line_lvl = 1'b0;
                    bit_pos = 4'd0;
                    tick_cnt = 8'd0;
                    line_phase = PH_DATA;
                    return 1'b1;
                end
                return 1'b0;
            end
            PH_DATA: begin
                if (tick_cnt >= bt) begin
                    line_lvl = shift_reg[bit_pos[2:0]];
                    tick_cnt = 8'd0;
                    bit_pos = bit_pos + 4'd1;
                    if (bit_pos >= DATA_BITS)
                        line_phase = PH_STOP;
                    return 1'b1;
                end
                return 1'b0;
            end
            default: begin
                if (tick_cnt >= bt) begin
                    line_lvl = 1'b1;
                    bit_pos = 4'd0;
                    tick_cnt = 8'd0;
                    line_phase = PH_GAP;
                    return 1'b1;
                end
                return 1'b0;
            end
        endcase
    endfunction

    function automatic t_result predict_line(input t_item it);
        t_result    r;
        logic       drop;
        logic [2:0] next_head;
        drop = 1'b0;
        if (it.opcode == OP_TICK) begin
            if (tick_cnt != TICK_MAX)
                tick_cnt = tick_cnt + 8'd1;
        end else begin
            if (fill_pos < BYTES) begin
                msg_mem[{head, fill_pos[3:0]}] = it.data_byte;
                fill_pos = fill_pos + 5'd1;
            end else begin
                drop = 1'b1;
            end
            if (it.last_byte) begin
                next_head = head + 3'd1;
                if (next_head == tail) begin
                    drop = 1'b1;
                end else begin
                    msg_len[head] = fill_pos;
                    head = next_head;
                end
                fill_pos = 5'd0;
            end
        end
        for (int n = 0; n < 16; n++) begin
            if (!sender_advance())
                break;
        end
        r.tx_line = line_lvl;
        r.busy_res = (line_phase != PH_IDLE);
        r.dropped = drop;
        r.pending = head - tail;
        return r;
    endfunction

    task automatic send_item(input t_item it, input logic typed, input t_result typed_res);
        t_result got;
        if (tx_calm > 0) begin
            tx_calm--;
        end else if (!quiet && $urandom_range(0, 39) == 0) begin
            tx_calm = $urandom_range(20, 80);
        end else if (!quiet && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_opcode <= it.opcode;
        i_data_byte <= it.data_byte;
        i_last_byte <= it.last_byte;
        do @(posedge i_clk); while (o_stall);
        got = predict_line(it);
        expected_lines.push_back(typed ? typed_res : got);
        items_sent++;
    endtask

    task automatic write_bit_ticks(input logic [7:0] value);
        i_valid <= 1'b0;
        while (expected_lines.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        bit_ticks_cfg = value;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || quiet) begin
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else if (rx_calm > 0) begin
            rx_calm <= rx_calm - 1;
            i_stall <= 1'b0;
        end else if ($urandom_range(0, 49) == 0) begin
            rx_calm <= $urandom_range(20, 80);
            i_stall <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 4);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_lines.size() == 0) begin
                $display("%0t: result with none expected: tx_line %0d busy %0d dropped %0d pending %0d",
                         $time, o_tx_line, o_busy_res, o_dropped, o_pending);
                errors++;
            end else begin
                want = expected_lines.pop_front();
                if (o_tx_line !== want.tx_line) begin
                    $display("%0t: tx_line expected %0d actual %0d", $time, want.tx_line, o_tx_line);
                    errors++;
                end
                if (o_busy_res !== want.busy_res) begin
                    $display("%0t: busy_res expected %0d actual %0d", $time, want.busy_res, o_busy_res);
                    errors++;
                end
                if (o_dropped !== want.dropped) begin
                    $display("%0t: dropped expected %0d actual %0d", $time, want.dropped, o_dropped);
                    errors++;
                end
                if (o_pending !== want.pending) begin
                    $display("%0t: pending expected %0d actual %0d", $time, want.pending, o_pending);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_queued_uart_bit_transmitter failed");
            $finish;
        end
    end

    initial begin
        t_item      it;
        logic [7:0] phase_ticks [6];
        int         phase_end;
        int         len;
        int         run;
        int         span;
        int         pick;

        line_phase = PH_IDLE;
        bit_pos = 4'd0;
        shift_reg = 8'd0;
        bit_ticks_cfg = BIT_TICKS_RESET;
        tick_cnt = BIT_TICKS_RESET;
        line_lvl = 1'b1;
        head = 3'd0;
        tail = 3'd0;
        fill_pos = 5'd0;
        send_pos = 5'd0;
        for (int s = 0; s < SLOTS; s++)
            msg_len[s] = 5'd0;
        for (int b = 0; b < SLOTS*BYTES; b++)
            msg_mem[b] = 8'd0;

        phase_ticks[0] = 8'd1;
        phase_ticks[1] = 8'd0;
        phase_ticks[2] = 8'd255;
        phase_ticks[3] = 8'd3;
        phase_ticks[4] = 8'($urandom_range(4, 12));
        phase_ticks[5] = 8'd2;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < NUM_ROWS; r++)
            send_item(DIRECTED_ROWS[r].it, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].res);

        for (int ph = 0; ph < 6; ph++) begin
            write_bit_ticks(phase_ticks[ph]);
            if (ph == 5)
                quiet = 1'b1;
            phase_end = NUM_ROWS + (ph + 1) * (TOTAL_ITEMS - NUM_ROWS) / 6;
            span = (phase_ticks[ph] == 8'd0) ? 30 : int'(phase_ticks[ph]) * 30;
            if (span > 300)
                span = 300;
            while (items_sent < phase_end) begin
                pick = $urandom_range(0, 9);
                if (pick < 6) begin
                    len = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 20)
                                                      : $urandom_range(1, 5);
                    for (int k = 0; k < len; k++) begin
                        it.opcode = OP_BYTE;
                        it.data_byte = 8'($urandom);
                        it.last_byte = (k == len - 1);
                        send_item(it, 1'b0, '0);
                    end
                end else if (pick < 9) begin
                    run = ($urandom_range(0, 19) == 0) ? 300 : $urandom_range(1, span);
                    for (int k = 0; k < run; k++) begin
                        it.opcode = OP_TICK;
                        it.data_byte = 8'($urandom);
                        it.last_byte = 1'($urandom_range(0, 1));
                        send_item(it, 1'b0, '0);
                    end
                end else begin
                    run = $urandom_range(1, 4);
                    for (int k = 0; k < run; k++) begin
                        it.opcode = 1'($urandom_range(0, 1));
                        it.data_byte = 8'($urandom);
                        it.last_byte = 1'($urandom_range(0, 1));
                        send_item(it, 1'b0, '0);
                    end
                end
            end
        end

        i_valid <= 1'b0;
        while (expected_lines.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (errors == 0 && expected_lines.size() == 0) begin
            $display("tb_queued_uart_bit_transmitter passed");
        end else begin
            $display("tb_queued_uart_bit_transmitter failed");
        end
        $finish;
    end

endmodule
